### hdl/ptro_pkg.sv
// shared types and constants for the point to rectangle outline distance block
`timescale 1ns / 1ps
`default_nettype none

package ptro_pkg;

	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;
	localparam int DIFF_W  = 18;
	localparam int MAG_W   = 16;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int RAD_W   = 34;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int DIST_W  = 18;
	localparam int CELLS   = ROOT_W;

	localparam logic [1:0] CFG_RECT_LEFT   = 2'd0;
	localparam logic [1:0] CFG_RECT_TOP    = 2'd1;
	localparam logic [1:0] CFG_RECT_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_RECT_HEIGHT = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} req_t;

	typedef struct packed {
		logic [DIST_W-1:0] edge_distance;
		logic              inside_flag;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [SIZE_W-1:0]         width;
		logic [SIZE_W-1:0]         height;
	} rect_t;

	// data handed from one square-root cell to the next
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic              in_rect;
		logic [MAG_W-1:0]  in_min;
	} sqrt_cell_t;

endpackage

`default_nettype wire

### hdl/ptro_front.sv
// front pipeline: edge offsets, outside distances, squares and radicand
`timescale 1ns / 1ps
`default_nettype none

module ptro_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire ptro_pkg::req_t       req,
	output logic                      req_ready,
	input  wire ptro_pkg::rect_t      rect,
	output logic                      dn_valid,
	output ptro_pkg::sqrt_cell_t      dn,
	input  wire logic                 dn_ready
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [ptro_pkg::DIFF_W-1:0] dl_s1, dr_s1, dt_s1, db_s1;
	logic [ptro_pkg::MAG_W-1:0]         dx_s2, dy_s2, min_s2;
	logic                               inside_s2;
	logic [ptro_pkg::SQ_W-1:0]          sqx_s3, sqy_s3;
	logic [ptro_pkg::MAG_W-1:0]         min_s3;
	logic                               inside_s3;
	ptro_pkg::sqrt_cell_t               cell_s4;

	logic signed [ptro_pkg::DIFF_W-1:0] l_ext, t_ext, r_ext, b_ext, x_ext, y_ext;
	logic [ptro_pkg::MAG_W-1:0]         dx_c, dy_c, min_a, min_b, min_c;
	logic                               inside_c;

	assign rdy_s4    = !v_s4 || dn_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;
	assign dn_valid  = v_s4;
	assign dn        = cell_s4;

	// edges at full width, right and bottom not wrapped
	always_comb begin
		l_ext = ptro_pkg::DIFF_W'(rect.left);
		t_ext = ptro_pkg::DIFF_W'(rect.top);
		r_ext = l_ext + $signed(ptro_pkg::DIFF_W'(rect.width));
		b_ext = t_ext + $signed(ptro_pkg::DIFF_W'(rect.height));
		x_ext = ptro_pkg::DIFF_W'(req.point_x);
		y_ext = ptro_pkg::DIFF_W'(req.point_y);
	end

	// distance outside each axis span, and least edge offset when inside
	always_comb begin
		if (dl_s1[ptro_pkg::DIFF_W-1]) begin
			dx_c = ptro_pkg::MAG_W'(-dl_s1);
		end else if (dr_s1[ptro_pkg::DIFF_W-1]) begin
			dx_c = ptro_pkg::MAG_W'(-dr_s1);
		end else begin
			dx_c = '0;
		end
		if (dt_s1[ptro_pkg::DIFF_W-1]) begin
			dy_c = ptro_pkg::MAG_W'(-dt_s1);
		end else if (db_s1[ptro_pkg::DIFF_W-1]) begin
			dy_c = ptro_pkg::MAG_W'(-db_s1);
		end else begin
			dy_c = '0;
		end
		inside_c = !(dl_s1[ptro_pkg::DIFF_W-1] || dr_s1[ptro_pkg::DIFF_W-1] ||
			dt_s1[ptro_pkg::DIFF_W-1] || db_s1[ptro_pkg::DIFF_W-1]);
		min_a = (dl_s1[ptro_pkg::MAG_W-1:0] < dr_s1[ptro_pkg::MAG_W-1:0]) ?
			dl_s1[ptro_pkg::MAG_W-1:0] : dr_s1[ptro_pkg::MAG_W-1:0];
		min_b = (dt_s1[ptro_pkg::MAG_W-1:0] < db_s1[ptro_pkg::MAG_W-1:0]) ?
			dt_s1[ptro_pkg::MAG_W-1:0] : db_s1[ptro_pkg::MAG_W-1:0];
		min_c = (min_a < min_b) ? min_a : min_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			dl_s1 <= x_ext - l_ext;
			dr_s1 <= r_ext - x_ext;
			dt_s1 <= y_ext - t_ext;
			db_s1 <= b_ext - y_ext;
		end
		if (rdy_s2 && v_s1) begin
			dx_s2     <= dx_c;
			dy_s2     <= dy_c;
			min_s2    <= min_c;
			inside_s2 <= inside_c;
		end
		if (rdy_s3 && v_s2) begin
			sqx_s3    <= ptro_pkg::SQ_W'(dx_s2) * ptro_pkg::SQ_W'(dx_s2);
			sqy_s3    <= ptro_pkg::SQ_W'(dy_s2) * ptro_pkg::SQ_W'(dy_s2);
			min_s3    <= min_s2;
			inside_s3 <= inside_s2;
		end
		if (rdy_s4 && v_s3) begin
			cell_s4.rad     <= ptro_pkg::RAD_W'(sqx_s3) + ptro_pkg::RAD_W'(sqy_s3);
			cell_s4.rem     <= '0;
			cell_s4.root    <= '0;
			cell_s4.in_rect <= inside_s3;
			cell_s4.in_min  <= min_s3;
		end
	end

endmodule

`default_nettype wire

### hdl/ptro_cell.sv
// one square-root cell: settles one root bit and passes the rest on
`timescale 1ns / 1ps
`default_nettype none

module ptro_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 up_valid,
	input  wire ptro_pkg::sqrt_cell_t up,
	output logic                      up_ready,
	output logic                      dn_valid,
	output ptro_pkg::sqrt_cell_t      dn,
	input  wire logic                 dn_ready
);

	logic                  valid_q;
	ptro_pkg::sqrt_cell_t  cell_q;
	ptro_pkg::sqrt_cell_t  step;
	logic [ptro_pkg::REM_W-1:0] rem_sh, trial;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn       = cell_q;

	// restoring digit step on the top two radicand bits
	always_comb begin
		rem_sh = {up.rem[ptro_pkg::REM_W-3:0], up.rad[ptro_pkg::RAD_W-1 -: 2]};
		trial  = {1'b0, up.root, 2'b01};
		step   = up;
		step.rad = {up.rad[ptro_pkg::RAD_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			step.rem  = rem_sh - trial;
			step.root = {up.root[ptro_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			step.rem  = rem_sh;
			step.root = {up.root[ptro_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			cell_q <= step;
		end
	end

	// remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cell_q.rem <= {2'b00, cell_q.root, 1'b0}))
		else $error("square-root remainder out of bound");

endmodule

`default_nettype wire

### hdl/point_to_rect_outline_distance.sv
// top level: configuration registers, front pipeline, square-root cell chain, result register
`timescale 1ns / 1ps
`default_nettype none

// Measures each requested point against the configured axis-aligned rectangle
// and returns the rounded distance to its nearest side together with an
// inclusive inside flag. One request is taken every cycle while the result
// side does not stall. The request passes twenty-two registers, the first
// loaded at the accepting edge: four front stages (edge offsets, outside
// distances, squares, sum of squares), a chain of seventeen square-root
// cells that each settle one bit of the root, and the result register.
// Points inside give the least perpendicular offset; points outside give the
// distance to the rectangle, rounded to the nearest integer. Stall travels
// back stage by stage, so empty stages keep taking requests while a result
// waits. The rectangle is written through cfg_we / cfg_index / cfg_data and
// must only change while no request is in flight.
module point_to_rect_outline_distance (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_stall,
	input  wire ptro_pkg::req_t          req,
	output logic                         rsp_valid,
	input  wire logic                    rsp_stall,
	output ptro_pkg::rsp_t               rsp,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [ptro_pkg::COORD_W-1:0] cfg_data
);

	// configuration registers
	ptro_pkg::rect_t rect_q;

	// cell chain links; link zero comes from the front pipeline
	logic                 link_valid [0:ptro_pkg::CELLS];
	logic                 link_ready [0:ptro_pkg::CELLS];
	ptro_pkg::sqrt_cell_t link       [0:ptro_pkg::CELLS];

	logic                 req_ready;
	logic                 out_ready;
	logic                 rsp_valid_q;
	ptro_pkg::rsp_t       rsp_q;
	ptro_pkg::sqrt_cell_t last;
	logic                 round_up;
	logic [ptro_pkg::DIST_W-1:0] dist_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptro_pkg::CFG_RECT_LEFT:   rect_q.left   <= cfg_data;
				ptro_pkg::CFG_RECT_TOP:    rect_q.top    <= cfg_data;
				ptro_pkg::CFG_RECT_WIDTH:  rect_q.width  <= cfg_data[ptro_pkg::SIZE_W-1:0];
				ptro_pkg::CFG_RECT_HEIGHT: rect_q.height <= cfg_data[ptro_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	ptro_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.rect      (rect_q),
		.dn_valid  (link_valid[0]),
		.dn        (link[0]),
		.dn_ready  (link_ready[0])
	);

	assign req_stall = !req_ready;

	// one cell per root bit, most significant first
	for (genvar i = 0; i < ptro_pkg::CELLS; i++) begin : g_cell
		ptro_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[i]),
			.up       (link[i]),
			.up_ready (link_ready[i]),
			.dn_valid (link_valid[i+1]),
			.dn       (link[i+1]),
			.dn_ready (link_ready[i+1])
		);
	end

	assign out_ready                   = !rsp_valid_q || !rsp_stall;
	assign link_ready[ptro_pkg::CELLS] = out_ready;
	assign last                        = link[ptro_pkg::CELLS];

	// round to nearest: up when the squared distance exceeds k*k + k
	always_comb begin
		round_up = last.rem > ptro_pkg::REM_W'(last.root);
		if (last.in_rect) begin
			dist_c = ptro_pkg::DIST_W'(last.in_min);
		end else begin
			dist_c = ptro_pkg::DIST_W'(last.root) + ptro_pkg::DIST_W'(round_up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ready) begin
			rsp_valid_q <= link_valid[ptro_pkg::CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && link_valid[ptro_pkg::CELLS]) begin
			rsp_q.edge_distance <= dist_c;
			rsp_q.inside_flag   <= last.in_rect;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// requests are only held off when every stage is full behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled with room in the pipeline");

	// an inside point is never farther than the largest side from an edge
	a_inside_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.inside_flag) |-> (rsp.edge_distance <= 18'd32767))
		else $error("inside distance out of range");

	// the farthest outside corner distance never exceeds the rounded root of 2*65535^2
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.edge_distance <= 18'd92682))
		else $error("edge distance out of range");

endmodule

`default_nettype wire

### test/tb_top.sv
// testbench for the point to rectangle outline distance block: random points against many rectangles
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_GAP       = 17;     // longest idle stretch drawn per request or result
	localparam int LONG_HOLD     = 200;    // result side hold-off that backs the pipeline up
	localparam int SETTLE        = 40;     // quiet cycles after the last result, above the latency
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_POINTS  = 90;
	localparam int TIMEOUT_NS    = 500000;

	// expected results, worked out from a private copy of the rectangle
	class distance_ledger_t;
		logic signed [ptro_pkg::COORD_W-1:0] left;
		logic signed [ptro_pkg::COORD_W-1:0] top;
		logic [ptro_pkg::SIZE_W-1:0]         width;
		logic [ptro_pkg::SIZE_W-1:0]         height;
		ptro_pkg::rsp_t                      due[$];
		int                                  errors;

		function new();
			left   = '0;
			top    = '0;
			width  = '0;
			height = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] index, logic [ptro_pkg::COORD_W-1:0] data);
			case (index)
				ptro_pkg::CFG_RECT_LEFT:   left   = data;
				ptro_pkg::CFG_RECT_TOP:    top    = data;
				ptro_pkg::CFG_RECT_WIDTH:  width  = data[ptro_pkg::SIZE_W-1:0];
				ptro_pkg::CFG_RECT_HEIGHT: height = data[ptro_pkg::SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		// nearest integer to the square root; a whole number never lies halfway
		function longint round_root(longint n);
			longint k;
			longint t;
			k = 0;
			for (int b = 17; b >= 0; b--) begin
				t = k | (longint'(1) << b);
				if (t * t <= n)
					k = t;
			end
			return (n - k * k > k) ? k + 1 : k;
		endfunction

		// p across the side at c, q along it between lo and hi
		function longint side_gap(longint p, longint q, longint c, longint lo, longint hi);
			longint across;
			longint along;
			across = (p > c) ? p - c : c - p;
			if (q >= lo && q <= hi)
				return across;
			along = (q < lo) ? lo - q : q - hi;
			return round_root(across * across + along * along);
		endfunction

		function ptro_pkg::rsp_t outline_distance(ptro_pkg::req_t p);
			longint x, y, l, t, r, b, wl, hl, best, d;
			ptro_pkg::rsp_t res;
			x    = $signed(p.point_x);
			y    = $signed(p.point_y);
			l    = left;
			t    = top;
			wl   = width;
			hl   = height;
			r    = l + wl;
			b    = t + hl;
			best = side_gap(x, y, l, t, b);
			d    = side_gap(y, x, t, l, r);
			if (d < best)
				best = d;
			d = side_gap(x, y, r, t, b);
			if (d < best)
				best = d;
			d = side_gap(y, x, b, l, r);
			if (d < best)
				best = d;
			res.edge_distance = best[ptro_pkg::DIST_W-1:0];
			res.inside_flag   = (x >= l && x <= r && y >= t && y <= b);
			return res;
		endfunction

		function void note_point(ptro_pkg::req_t p);
			due = {due, outline_distance(p)};
		endfunction

		function int pending();
			return due.size();
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(ptro_pkg::rsp_t got);
			ptro_pkg::rsp_t want;
			if (due.size() == 0) begin
				report($sformatf("result %0d/%0b with nothing outstanding",
					got.edge_distance, got.inside_flag));
				return;
			end
			want = due.pop_front();
			if (got.edge_distance !== want.edge_distance)
				report($sformatf("edge_distance %0d, wanted %0d",
					got.edge_distance, want.edge_distance));
			if (got.inside_flag !== want.inside_flag)
				report($sformatf("inside_flag %0b, wanted %0b",
					got.inside_flag, want.inside_flag));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	ptro_pkg::req_t                req;
	logic                          rsp_valid;
	logic                          rsp_stall;
	ptro_pkg::rsp_t                rsp;
	logic                          cfg_we;
	logic [1:0]                    cfg_index;
	logic [ptro_pkg::COORD_W-1:0]  cfg_data;

	bit                  no_gaps;    // both sides run flat out while set
	bit                  long_hold;  // asks the result side for one long hold-off
	distance_ledger_t    board;

	point_to_rect_outline_distance uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic signed [ptro_pkg::COORD_W-1:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[ptro_pkg::COORD_W-1:0];
	endfunction

	// mostly points around the rectangle and its corners, some anywhere in the plane
	function automatic ptro_pkg::req_t pick_point();
		ptro_pkg::req_t p;
		longint l, t, r, b, wl, hl;
		int     sel;
		l   = board.left;
		t   = board.top;
		wl  = board.width;
		hl  = board.height;
		r   = l + wl;
		b   = t + hl;
		sel = $urandom_range(0, 9);
		if (sel < 3) begin
			p = $urandom;
		end else if (sel < 8) begin
			p.point_x = clamp16(l - 40 + longint'($urandom_range(0, wl + 80)));
			p.point_y = clamp16(t - 40 + longint'($urandom_range(0, hl + 80)));
		end else begin
			p.point_x = clamp16(($urandom_range(0, 1) ? l : r) + longint'($urandom_range(0, 6)) - 3);
			p.point_y = clamp16(($urandom_range(0, 1) ? t : b) + longint'($urandom_range(0, 6)) - 3);
		end
		return p;
	endfunction

	// offer one request after a drawn gap and hold it until taken
	task automatic send_point(ptro_pkg::req_t p);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= p;
		do @(posedge clk); while (req_stall);
		board.note_point(p);
	endtask

	task automatic send_xy(int x, int y);
		ptro_pkg::req_t p;
		p.point_x = x[ptro_pkg::COORD_W-1:0];
		p.point_y = y[ptro_pkg::COORD_W-1:0];
		send_point(p);
	endtask

	// only called with nothing in flight
	task automatic load_rect(int l, int t, int w, int h);
		logic [1:0]                   idx[4];
		logic [ptro_pkg::COORD_W-1:0] val[4];
		idx = '{ptro_pkg::CFG_RECT_LEFT, ptro_pkg::CFG_RECT_TOP,
			ptro_pkg::CFG_RECT_WIDTH, ptro_pkg::CFG_RECT_HEIGHT};
		val = '{l[ptro_pkg::COORD_W-1:0], t[ptro_pkg::COORD_W-1:0],
			w[ptro_pkg::COORD_W-1:0], h[ptro_pkg::COORD_W-1:0]};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			board.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// sender stops until every outstanding result is back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// result side: random hold-offs, one long one on request, none while flat out
	initial begin
		int w;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				w         = LONG_HOLD;
				long_hold = 1'b0;
			end else if (no_gaps) begin
				w = 0;
			end else begin
				w = $urandom_range(0, MAX_GAP);
			end
			if (w > 0) begin
				rsp_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// every result taken is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_result(rsp);
	end

	initial begin
		board     = new();
		no_gaps   = 1'b0;
		long_hold = 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= ptro_pkg::CFG_RECT_LEFT;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset rectangle: a single point at the origin
		for (int i = 0; i < 10; i++)
			send_point(pick_point());
		drain();

		// directed: rectangle spanning x -10..20, y -20..20
		load_rect(-10, -20, 30, 40);
		// corners
		send_xy(-10, -20);
		send_xy(20, 20);
		send_xy(-10, 20);
		send_xy(20, -20);
		// on the sides, and inside
		send_xy(0, -20);
		send_xy(-10, 0);
		send_xy(5, 5);
		send_xy(0, 0);
		// beyond each side, foot of the perpendicular on the side
		send_xy(0, -30);
		send_xy(30, 0);
		send_xy(0, 45);
		send_xy(-30, 0);
		// beyond the corners, rounded end distances either side of the half
		send_xy(-15, -25);
		send_xy(-11, -21);
		send_xy(-12, -22);
		send_xy(-14, -22);
		send_xy(-13, -22);
		send_xy(25, 27);
		send_xy(-30, 30);
		// plane corners
		send_xy(-32768, -32768);
		send_xy(32767, 32767);
		send_xy(-32768, 32767);
		send_xy(32767, -32768);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				// far corner: right and bottom edges beyond 16 bits, width bit 15 ignored
				0: load_rect(32767, 32767, 'hffff, 'h7fff);
				// collapsed to a point at the most negative corner
				1: load_rect(-32768, -32768, 0, 0);
				// flat and thin rectangles
				2: load_rect(-32768, 32767, 'h7fff, 0);
				3: load_rect(0, -32768, 0, 'h7fff);
				default: begin
					load_rect($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535),
						$urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535));
				end
			endcase
			// one phase in three runs with no idling; phase four also backs the block up
			no_gaps = (phase % 3 == 2) || (phase == 4);
			for (int i = 0; i < PHASE_POINTS; i++) begin
				if (phase == 4 && i == 10)
					long_hold = 1'b1;
				send_point(pick_point());
			end
			drain();
		end
		no_gaps = 1'b0;

		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
